// ----- sv/bbps_pkg.sv -----
// Shared types, wall limits and fixed-point helpers for the box bounce step unit.
`default_nettype none
package bbps_pkg;
	localparam longint LIM_TOP   = 80 * 65536;
	localparam longint LIM_BOT   = -80 * 65536;
	localparam longint LIM_LEFT  = -120 * 65536;
	localparam longint LIM_RIGHT = 120 * 65536;
	localparam longint LIM_BACK  = -400 * 65536;
	localparam longint LIM_FRONT = -100 * 65536;

	localparam logic [1:0] REG_GRAVITY    = 2'd0;
	localparam logic [1:0] REG_TIME_STEP  = 2'd1;
	localparam logic [1:0] REG_ELASTICITY = 2'd2;
	localparam logic [1:0] REG_FRICTION   = 2'd3;

	localparam int NWALL = 6;
	localparam int WALL_STAGES = 4;
	localparam int INTEG_STAGES = 4;

	typedef struct packed {
		logic [2:0][31:0] r;
		logic [2:0][31:0] w;
		logic [2:0][31:0] v;
		logic [2:0][31:0] p;
		logic             top;
		logic             bot;
	} obj_t;

	function automatic logic [31:0] sat32(input logic signed [63:0] a);
		logic [31:0] res;
		if (a > 64'sd2147483647) res = 32'h7fff_ffff;
		else if (a < -64'sd2147483648) res = 32'h8000_0000;
		else res = a[31:0];
		return res;
	endfunction

	// round half up, then shift right by n
	function automatic logic signed [63:0] rnd(input logic signed [63:0] a, input int n);
		logic signed [63:0] res;
		res = (a + (64'sd1 <<< (n - 1))) >>> n;
		return res;
	endfunction

	function automatic logic signed [63:0] ext(input logic [31:0] a);
		logic signed [63:0] res;
		res = 64'($signed(a));
		return res;
	endfunction
endpackage
`default_nettype wire

// ----- sv/box_bounce_particle_step_unit.sv -----
// Top level: one step of a point object bouncing inside a fixed box.
// Input stream s_*: one object word per cycle while s_tready is high (position,
// velocity, spin, rotation, all Q16.16). Output stream m_*: the advanced object,
// one word per input word, in order.
// The six walls are tested one after another, four register stages per wall
// (predict and bounce product, compare and clamp, friction products, coupling),
// then four stages of gravity and integration: 28 stages in all; throughput one
// word per cycle while m_tready is high.
// The pipeline advances as one; when m_tvalid is high and m_tready low every
// stage holds and s_tready falls, so nothing is lost or repeated.
// Configuration: cfg_we writes register cfg_index (0 gravity, 1 time step,
// 2 elasticity, 3 friction) from cfg_data; write only while the pipeline is
// empty. The friction times time step factor is registered from the stored values.
// Reset empties the pipeline and loads gravity 642253, time step 1049,
// elasticity 65536, friction 0.
`default_nettype none
module box_bounce_particle_step_unit import bbps_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// pos_x,pos_y,pos_z,vel_x,vel_y,vel_z,spin_x,spin_y,spin_z,rot_x,rot_y,rot_z
	input  wire logic [383:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// new_pos_x..z, new_vel_x..z, new_spin_x..z, new_rot_x..z
	output logic [383:0]      m_tdata,
	input  wire logic         cfg_we,
	input  wire logic [1:0]   cfg_index,
	input  wire logic [31:0]  cfg_data
);
	logic [31:0] grav_q;
	logic [15:0] dt_q;
	logic [16:0] el_q, fr_q;
	logic [25:0] k_q;
	logic [33:0] kprod;
	logic        en;

	logic valid_w [NWALL+1];
	obj_t obj_w   [NWALL+1];
	obj_t obj_in;
	obj_t obj_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= 32'd642253;
			dt_q   <= 16'd1049;
			el_q   <= 17'd65536;
			fr_q   <= 17'd0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRAVITY:    grav_q <= cfg_data;
				REG_TIME_STEP:  dt_q   <= cfg_data[15:0];
				REG_ELASTICITY: el_q   <= cfg_data[16:0];
				REG_FRICTION:   fr_q   <= cfg_data[16:0];
				default:  ;
			endcase
		end
	end

	assign kprod = 34'(fr_q) * 34'(dt_q) + 34'd128;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) k_q <= '0;
		else k_q <= kprod[33:8];
	end

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			obj_in.p[i] = s_tdata[32*i +: 32];
			obj_in.v[i] = s_tdata[96 + 32*i +: 32];
			obj_in.w[i] = s_tdata[192 + 32*i +: 32];
			obj_in.r[i] = s_tdata[288 + 32*i +: 32];
		end
		obj_in.top = 1'b0;
		obj_in.bot = 1'b0;
	end
	assign obj_w[0]   = obj_in;
	assign valid_w[0] = s_tvalid;

	for (genvar g = 0; g < NWALL; g++) begin : g_wall
		bbps_wall #(.WALL(g)) u_wall (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (valid_w[g]),
			.in_obj    (obj_w[g]),
			.dt        (dt_q),
			.elast     (el_q),
			.k         (k_q),
			.out_valid (valid_w[g+1]),
			.out_obj   (obj_w[g+1])
		);
	end

	bbps_integ u_integ (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (valid_w[NWALL]),
		.in_obj    (obj_w[NWALL]),
		.grav      (grav_q),
		.dt        (dt_q),
		.out_valid (m_tvalid),
		.out_obj   (obj_out)
	);

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			m_tdata[32*i +: 32]       = obj_out.p[i];
			m_tdata[96 + 32*i +: 32]  = obj_out.v[i];
			m_tdata[192 + 32*i +: 32] = obj_out.w[i];
			m_tdata[288 + 32*i +: 32] = obj_out.r[i];
		end
	end
endmodule
`default_nettype wire

// ----- sv/bbps_wall.sv -----
// One wall test: predict, clamp and bounce, friction coupling; four stages.
`default_nettype none
module bbps_wall import bbps_pkg::*; #(
	parameter int WALL = 0
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        in_valid,
	input  wire obj_t        in_obj,
	input  wire logic [15:0] dt,
	input  wire logic [16:0] elast,
	input  wire logic [25:0] k,
	output logic             out_valid,
	output obj_t             out_obj
);
	localparam int AX = (WALL < 2) ? 1 : ((WALL < 4) ? 0 : 2);
	localparam bit UPPER = (WALL == 0) || (WALL == 3) || (WALL == 5);
	localparam longint LIM = (WALL == 0) ? LIM_TOP : (WALL == 1) ? LIM_BOT :
		(WALL == 2) ? LIM_LEFT : (WALL == 3) ? LIM_RIGHT :
		(WALL == 4) ? LIM_BACK : LIM_FRONT;
	localparam logic [31:0] LIM32 = 32'(LIM);

	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	obj_t                obj_s1, obj_s2, obj_s3, obj_s4;
	logic signed [48:0]  pred_s1;
	logic [48:0]         mag_s1;
	logic                hit_s2, hit_s3;
	logic signed [58:0]  fwx_s3, fwy_s3, fwz_s3, fvx_s3;

	logic [31:0]         vin, vabs;
	logic signed [63:0]  psum, mag;
	logic                hit;
	obj_t                obj2, obj4;
	logic signed [63:0]  fwx, fwy, fwz, fvx;

	assign vin  = in_obj.v[AX];
	assign vabs = vin[31] ? (~vin + 32'd1) : vin;

	always_ff @(posedge clk) begin
		if (en) begin
			obj_s1  <= in_obj;
			pred_s1 <= $signed(vin) * $signed({1'b0, dt});
			mag_s1  <= vabs * elast;
		end
	end

	always_comb begin
		psum = ext(obj_s1.p[AX]) + rnd(64'(pred_s1), 16);
		mag  = rnd($signed({15'd0, mag_s1}), 16);
		hit  = UPPER ? (psum > 64'(LIM)) : (psum < 64'(LIM));
		obj2 = obj_s1;
		if (hit) begin
			obj2.p[AX] = LIM32;
			obj2.v[AX] = UPPER ? sat32(-mag) : sat32(mag);
			if (WALL == 0) obj2.top = 1'b1;
			if (WALL == 1) obj2.bot = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			obj_s2 <= obj2;
			hit_s2 <= hit;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			obj_s3 <= obj_s2;
			hit_s3 <= hit_s2;
			fwx_s3 <= $signed(obj_s2.w[0]) * $signed({1'b0, k});
			fwy_s3 <= $signed(obj_s2.w[1]) * $signed({1'b0, k});
			fwz_s3 <= $signed(obj_s2.w[2]) * $signed({1'b0, k});
			fvx_s3 <= $signed(obj_s2.v[0]) * $signed({1'b0, k});
		end
	end

	always_comb begin
		fwx  = rnd(64'(fwx_s3), 24);
		fwy  = rnd(64'(fwy_s3), 24);
		fwz  = rnd(64'(fwz_s3), 24);
		fvx  = rnd(64'(fvx_s3), 24);
		obj4 = obj_s3;
		if (hit_s3) begin
			if (AX == 1) begin
				obj4.v[0] = sat32(ext(obj_s3.v[0]) - fwz);
				obj4.v[2] = sat32(ext(obj_s3.v[2]) + fwx);
				obj4.w[2] = sat32(ext(obj_s3.w[2]) - fwz - fvx);
			end else if (AX == 0) begin
				obj4.v[1] = sat32(ext(obj_s3.v[1]) - fwx);
				obj4.v[2] = sat32(ext(obj_s3.v[2]) + fwy);
				obj4.w[0] = sat32(ext(obj_s3.w[0]) - fwx - fvx);
			end else begin
				obj4.v[0] = sat32(ext(obj_s3.v[0]) - fwz);
				obj4.v[1] = sat32(ext(obj_s3.v[1]) - fwx);
				obj4.w[0] = sat32(ext(obj_s3.w[0]) - fwx - fvx);
				obj4.w[2] = sat32(ext(obj_s3.w[2]) - fwz);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) obj_s4 <= obj4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_obj   = obj_s4;

	a_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && hit_s2 |-> obj_s2.p[AX] == LIM32)
		else $error("hit without clamp");
	a_dir: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && hit_s2 |-> (UPPER ? !($signed(obj_s2.v[AX]) > 0)
			: !($signed(obj_s2.v[AX]) < 0)))
		else $error("bounce points into wall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s4) && $stable(obj_s4))
		else $error("stage moved during stall");
endmodule
`default_nettype wire

// ----- sv/bbps_integ.sv -----
// Gravity and velocity update, then position and rotation integration; four stages.
`default_nettype none
module bbps_integ import bbps_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_valid,
	input  wire obj_t         in_obj,
	input  wire logic [31:0]  grav,
	input  wire logic [15:0]  dt,
	output logic              out_valid,
	output obj_t              out_obj
);
	logic                vld_s1, vld_s2, vld_s3, vld_s4;
	obj_t                obj_s1, obj_s2, obj_s3, obj_s4;
	logic signed [50:0]  acc_s1;
	logic signed [48:0]  pv_s3 [3];
	logic signed [48:0]  pw_s3 [3];
	logic signed [33:0]  ay;
	obj_t                obj2, obj4;

	always_comb begin
		if (in_obj.top && !in_obj.bot) ay = -($signed({{2{grav[31]}}, grav}) <<< 1);
		else if (in_obj.bot && !in_obj.top) ay = '0;
		else ay = -$signed({{2{grav[31]}}, grav});
	end

	always_ff @(posedge clk) begin
		if (en) begin
			obj_s1 <= in_obj;
			acc_s1 <= ay * $signed({1'b0, dt});
		end
	end

	always_comb begin
		obj2      = obj_s1;
		obj2.v[1] = sat32(ext(obj_s1.v[1]) + rnd(64'(acc_s1), 16));
	end

	always_ff @(posedge clk) begin
		if (en) obj_s2 <= obj2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			obj_s3 <= obj_s2;
			for (int i = 0; i < 3; i++) begin
				pv_s3[i] <= $signed(obj_s2.v[i]) * $signed({1'b0, dt});
				pw_s3[i] <= $signed(obj_s2.w[i]) * $signed({1'b0, dt});
			end
		end
	end

	always_comb begin
		obj4 = obj_s3;
		for (int i = 0; i < 3; i++) begin
			obj4.p[i] = sat32(ext(obj_s3.p[i]) + rnd(64'(pv_s3[i]), 16));
			obj4.r[i] = sat32(ext(obj_s3.r[i]) + rnd(64'(pw_s3[i]), 16));
		end
	end

	always_ff @(posedge clk) begin
		if (en) obj_s4 <= obj4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_obj   = obj_s4;

	a_spin: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s3 |=> obj_s4.w == $past(obj_s3.w))
		else $error("spin changed in integrator");
	a_vel: assert property (@(posedge clk) disable iff (!arst_n)
		en && vld_s3 |=> obj_s4.v == $past(obj_s3.v))
		else $error("velocity changed after gravity");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s4) && $stable(obj_s4))
		else $error("output moved during stall");
endmodule
`default_nettype wire
